// File: design/texture_modulate_pixel_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the texture modulation block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXTURE_MODULATE_PIXEL_MACROS_SVH
`define TEXTURE_MODULATE_PIXEL_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("texture modulation assertion failed");

// Consequent checked in the cycle after the antecedent.
`define TM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("texture modulation assertion failed");

`endif

// File: design/texmod_pkg.sv
// ----------------------------------------------------------------------------
// Texture modulation package
// Word types, configuration record, constants and the divider step.
// ----------------------------------------------------------------------------
package texmod_pkg;

  localparam int CHAN_W         = 8;
  localparam int KEEP_W         = 17;
  localparam int GAIN_W         = 24;
  localparam int QUO_W          = 16;
  localparam int DIV_STAGES     = 4;
  localparam int NUM_LANES      = 3;
  localparam int VLD_STAGES     = 7;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 17;

  localparam logic [KEEP_W-1:0] KEEP_ONE  = 17'h10000;
  localparam logic [KEEP_W-1:0] KEEP_RST  = 17'h08000;
  localparam logic [CHAN_W-1:0] BASE_RST  = 8'd128;
  localparam logic [CHAN_W-1:0] BASE_MIN  = 8'd1;
  localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'hFF;

  localparam logic [CFG_IDX_W-1:0] REG_KEEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd2;

  localparam logic MODE_GRAY  = 1'b0;
  localparam logic MODE_COLOR = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] chan_a;
    logic [CHAN_W-1:0] chan_b;
    logic [CHAN_W-1:0] chan_c;
    logic [CHAN_W-1:0] texture_level;
  } in_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_a;
    logic [CHAN_W-1:0] out_b;
    logic [CHAN_W-1:0] out_c;
  } out_word_t;

  typedef struct packed {
    logic [KEEP_W-1:0] keep;
    logic [CHAN_W-1:0] base;
    logic              mode;
  } cfg_t;

  typedef struct packed {
    logic [CHAN_W-1:0] res;
    logic [CHAN_W-1:0] raw;
  } lane_res_t;

  typedef struct packed {
    logic [QUO_W-1:0] rem;
    logic [1:0]       bits;
  } div_step_t;

  // Two restoring division steps: quotient bits hi_sh and hi_sh-1.
  function automatic div_step_t div_step2(logic [QUO_W-1:0]  rem,
                                          logic [CHAN_W-1:0] base,
                                          logic [2:0]        hi_sh);
    logic [QUO_W:0]   d;
    logic [QUO_W-1:0] r;
    div_step_t        st;
    r = rem;
    d = {{(QUO_W+1-CHAN_W){1'b0}}, base} << hi_sh;
    if ({1'b0, r} >= d) begin
      r = r - d[QUO_W-1:0];
      st.bits[1] = 1'b1;
    end else begin
      st.bits[1] = 1'b0;
    end
    d = {{(QUO_W+1-CHAN_W){1'b0}}, base} << (hi_sh - 3'd1);
    if ({1'b0, r} >= d) begin
      r = r - d[QUO_W-1:0];
      st.bits[0] = 1'b1;
    end else begin
      st.bits[0] = 1'b0;
    end
    st.rem = r;
    return st;
  endfunction

endpackage

// File: design/texmod_gain.sv
// ----------------------------------------------------------------------------
// Texture modulation gain stage
// Forms the shared gain keep*base + (1-keep)*texture for all lanes.
// ----------------------------------------------------------------------------
module texmod_gain import texmod_pkg::*; (
  input  logic              clk,
  input  logic              stage_en,
  input  cfg_t              cfg,
  input  logic [CHAN_W-1:0] texture_level,
  output logic [GAIN_W-1:0] gain
);

  logic [KEEP_W-1:0]   rest;
  logic [KEEP_W+CHAN_W-1:0] prod_keep;
  logic [KEEP_W+CHAN_W-1:0] prod_tex;
  logic [KEEP_W+CHAN_W-1:0] sum;
  logic [GAIN_W-1:0]   gain_r;
  logic [GAIN_W-1:0]   gain_nxt;

  always_comb begin
    rest      = KEEP_ONE - cfg.keep;
    prod_keep = cfg.keep * cfg.base;
    prod_tex  = rest * texture_level;
    sum       = prod_keep + prod_tex;
    gain_nxt  = sum[GAIN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      gain_r <= gain_nxt;
    end
  end

  assign gain = gain_r;

endmodule

// File: design/texmod_lane.sv
// ----------------------------------------------------------------------------
// Texture modulation channel lane
// Scales one channel by the gain and divides by the base, two bits a stage.
// ----------------------------------------------------------------------------
module texmod_lane import texmod_pkg::*; (
  input  logic              clk,
  input  logic              stage_en,
  input  cfg_t              cfg,
  input  logic [CHAN_W-1:0] chan,
  input  logic [GAIN_W-1:0] gain,
  output lane_res_t         result
);

  logic [CHAN_W-1:0] p_r;
  logic [CHAN_W-1:0] raw2_r;
  logic [QUO_W-1:0]  q_r;
  logic [QUO_W-1:0]  q_nxt;
  logic [CHAN_W-1:0] raw3_r;
  logic [CHAN_W+GAIN_W-1:0] prod;
  logic [QUO_W-1:0]  sat_thr;

  logic [QUO_W-1:0]  rem_r   [DIV_STAGES];
  logic [QUO_W-1:0]  rem_nxt [DIV_STAGES];
  logic [CHAN_W-1:0] quo_r   [DIV_STAGES];
  logic [CHAN_W-1:0] quo_nxt [DIV_STAGES];
  logic              sat_r   [DIV_STAGES];
  logic              sat_nxt [DIV_STAGES];
  logic [CHAN_W-1:0] raw_r   [DIV_STAGES];
  logic [CHAN_W-1:0] raw_nxt [DIV_STAGES];

  always_comb begin
    prod    = p_r * gain;
    q_nxt   = prod[CHAN_W+GAIN_W-1:CHAN_W+GAIN_W-QUO_W];
    sat_thr = {cfg.base, {CHAN_W{1'b0}}} - {{(QUO_W-CHAN_W){1'b0}}, cfg.base};
  end

  always_comb begin
    div_step_t         st;
    logic [QUO_W-1:0]  rem_src;
    logic [CHAN_W-1:0] quo_src;
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (s == 0) begin
        rem_src    = q_r;
        quo_src    = '0;
        sat_nxt[s] = (q_r >= sat_thr);
        raw_nxt[s] = raw3_r;
      end else begin
        rem_src    = rem_r[s-1];
        quo_src    = quo_r[s-1];
        sat_nxt[s] = sat_r[s-1];
        raw_nxt[s] = raw_r[s-1];
      end
      st         = div_step2(rem_src, cfg.base, 3'(CHAN_W - 1 - 2 * s));
      rem_nxt[s] = st.rem;
      quo_nxt[s] = {quo_src[CHAN_W-3:0], st.bits};
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      p_r    <= chan;
      raw2_r <= chan;
      q_r    <= q_nxt;
      raw3_r <= raw2_r;
      for (int s = 0; s < DIV_STAGES; s++) begin
        rem_r[s] <= rem_nxt[s];
        quo_r[s] <= quo_nxt[s];
        sat_r[s] <= sat_nxt[s];
        raw_r[s] <= raw_nxt[s];
      end
    end
  end

  assign result.res = sat_r[DIV_STAGES-1] ? CHAN_MAX : quo_r[DIV_STAGES-1];
  assign result.raw = raw_r[DIV_STAGES-1];

endmodule

// File: design/texmod_merge.sv
// ----------------------------------------------------------------------------
// Texture modulation merge stage
// Combines the lane results into one output word and holds it for the sink.
// ----------------------------------------------------------------------------
module texmod_merge import texmod_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      stage_en,
  input  cfg_t      cfg,
  input  logic      lane_valid,
  input  lane_res_t lane_a,
  input  lane_res_t lane_b,
  input  lane_res_t lane_c,
  output logic      out_valid,
  output out_word_t out_data
);

  logic      out_valid_r;
  out_word_t out_data_r;
  out_word_t out_data_nxt;

  always_comb begin
    out_data_nxt.out_a = lane_a.res;
    if (cfg.mode == MODE_COLOR) begin
      out_data_nxt.out_b = lane_b.res;
      out_data_nxt.out_c = lane_c.res;
    end else begin
      out_data_nxt.out_b = lane_b.raw;
      out_data_nxt.out_c = lane_c.raw;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_en) begin
      out_valid_r <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/texture_modulate_pixel.sv
// ----------------------------------------------------------------------------
// Texture modulation blend of one pixel
// Blends chan_a, and in color mode chan_b and chan_c too, between its original and its texture-scaled value.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Word
// in_       input      in_valid/in_ready    chan_a, chan_b, chan_c, texture_level
// out_      output     out_valid/out_ready  out_a, out_b, out_c
// cfg_      input      cfg_we               cfg_index, cfg_data
//
// One word is accepted every cycle unless the output stalls; each result passes
// through the input register, the gain and product multipliers and the four-stage
// divider in each channel lane, two quotient bits per stage, to the output register.
// All stages advance together whenever the output register is empty or taken.
// Reset clears the valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`include "texture_modulate_pixel_macros.svh"

module texture_modulate_pixel import texmod_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic                  stage_en;
  logic [KEEP_W-1:0]     keep_r;
  logic [CHAN_W-1:0]     base_r;
  logic                  mode_r;
  cfg_t                  cfg;
  logic [VLD_STAGES-1:0] vld_r;
  logic [VLD_STAGES-1:0] vld_nxt;
  in_word_t              in_r;
  logic [GAIN_W-1:0]     gain;
  lane_res_t             lane_res [NUM_LANES];
  logic [CHAN_W-1:0]     lane_chan [NUM_LANES];

  assign stage_en = !out_valid || out_ready;
  assign in_ready = stage_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= KEEP_RST;
      base_r <= BASE_RST;
      mode_r <= MODE_GRAY;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEEP: begin
          keep_r <= (cfg_data > KEEP_ONE) ? KEEP_ONE : cfg_data[KEEP_W-1:0];
        end
        REG_BASE: begin
          base_r <= (cfg_data[CHAN_W-1:0] == '0) ? BASE_MIN : cfg_data[CHAN_W-1:0];
        end
        REG_MODE: begin
          mode_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.keep = keep_r;
  assign cfg.base = base_r;
  assign cfg.mode = mode_r;

  assign vld_nxt = {vld_r[VLD_STAGES-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (stage_en) begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en) begin
      in_r <= in_data;
    end
  end

  texmod_gain u_gain (
    .clk           (clk),
    .stage_en      (stage_en),
    .cfg           (cfg),
    .texture_level (in_r.texture_level),
    .gain          (gain)
  );

  assign lane_chan[0] = in_r.chan_a;
  assign lane_chan[1] = in_r.chan_b;
  assign lane_chan[2] = in_r.chan_c;

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    texmod_lane u_lane (
      .clk      (clk),
      .stage_en (stage_en),
      .cfg      (cfg),
      .chan     (lane_chan[i]),
      .gain     (gain),
      .result   (lane_res[i])
    );
  end

  texmod_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .stage_en   (stage_en),
    .cfg        (cfg),
    .lane_valid (vld_r[VLD_STAGES-1]),
    .lane_a     (lane_res[0]),
    .lane_b     (lane_res[1]),
    .lane_c     (lane_res[2]),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

  `TM_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld_r[0])
  `TM_ASSERT_NEXT(a_stall_holds, !stage_en, $stable(vld_r))
  `TM_ASSERT_NEXT(a_base_zero_sat,
                  cfg_we && cfg_index == REG_BASE && cfg_data[CHAN_W-1:0] == '0,
                  base_r == BASE_MIN)
  `TM_ASSERT_NEXT(a_keep_clamp,
                  cfg_we && cfg_index == REG_KEEP && cfg_data > KEEP_ONE,
                  keep_r == KEEP_ONE)

endmodule

// File: sim/tb_texture_modulate_pixel.sv
// ----------------------------------------------------------------------------
// Testbench for the texture modulation pixel blend
// Streams pixels through the block under several register settings, predicts
// the words the directed table does not give and compares each field.
// A directed table covers extremes and saturation; random phases follow with
// random gaps on both channels, one long output stall and one full drain.
// ----------------------------------------------------------------------------
module tb_texture_modulate_pixel;
  import texmod_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 16;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 50;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic              set_cfg;
    logic [KEEP_W-1:0] keep_raw;
    logic [CHAN_W-1:0] base_raw;
    logic              mode_raw;
    in_word_t          pix;
    logic              typed;
    out_word_t         want;
  } step_row_t;

  localparam step_row_t DIRECTED [16] = '{
    '{1'b0, 17'd0,      8'd0,   MODE_GRAY,  {8'd0,   8'd0,   8'd0,   8'd0},
      1'b1, {8'd0,   8'd0,   8'd0}},
    '{1'b0, 17'd0,      8'd0,   MODE_GRAY,  {8'd255, 8'd255, 8'd255, 8'd255},
      1'b1, {8'd255, 8'd255, 8'd255}},
    '{1'b0, 17'd0,      8'd0,   MODE_GRAY,  {8'd200, 8'd17,  8'd99,  8'd128},
      1'b1, {8'd200, 8'd17,  8'd99}},
    '{1'b1, 17'h1FFFF,  8'd40,  MODE_COLOR, {8'd12,  8'd34,  8'd56,  8'd255},
      1'b1, {8'd12,  8'd34,  8'd56}},
    '{1'b0, 17'h1FFFF,  8'd40,  MODE_COLOR, {8'd255, 8'd0,   8'd128, 8'd0},
      1'b1, {8'd255, 8'd0,   8'd128}},
    '{1'b1, 17'd0,      8'd0,   MODE_COLOR, {8'd1,   8'd2,   8'd0,   8'd1},
      1'b1, {8'd1,   8'd2,   8'd0}},
    '{1'b0, 17'd0,      8'd0,   MODE_COLOR, {8'd255, 8'd1,   8'd0,   8'd255},
      1'b1, {8'd255, 8'd255, 8'd0}},
    '{1'b0, 17'd0,      8'd0,   MODE_COLOR, {8'd16,  8'd15,  8'd17,  8'd16},
      1'b1, {8'd255, 8'd240, 8'd255}},
    '{1'b1, 17'd0,      8'd255, MODE_COLOR, {8'd255, 8'd128, 8'd1,   8'd0},
      1'b1, {8'd0,   8'd0,   8'd0}},
    '{1'b0, 17'd0,      8'd255, MODE_COLOR, {8'd255, 8'd128, 8'd1,   8'd255},
      1'b1, {8'd255, 8'd128, 8'd1}},
    '{1'b0, 17'd0,      8'd255, MODE_COLOR, {8'd100, 8'd200, 8'd50,  8'd77},
      1'b0, 24'd0},
    '{1'b1, 17'd1,      8'd255, MODE_GRAY,  {8'd255, 8'd170, 8'd85,  8'd254},
      1'b0, 24'd0},
    '{1'b0, 17'd1,      8'd255, MODE_GRAY,  {8'd85,  8'd170, 8'd85,  8'd170},
      1'b0, 24'd0},
    '{1'b1, 17'd65535,  8'd1,   MODE_COLOR, {8'd255, 8'd255, 8'd255, 8'd255},
      1'b0, 24'd0},
    '{1'b0, 17'd65535,  8'd1,   MODE_COLOR, {8'd1,   8'd0,   8'd254, 8'd0},
      1'b0, 24'd0},
    '{1'b1, 17'h10000,  8'd128, MODE_GRAY,  {8'd128, 8'd255, 8'd0,   8'd255},
      1'b1, {8'd128, 8'd255, 8'd0}}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_KEEP;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [KEEP_W-1:0] keep_q = KEEP_RST;
  logic [CHAN_W-1:0] base_q = BASE_RST;
  logic              mode_q = MODE_GRAY;

  out_word_t   blended_q [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;
  int unsigned stall_left = 0;
  logic        smooth_flow = 1'b0;

  texture_modulate_pixel DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] p,
                                                   input logic [CHAN_W-1:0] t);
    longint unsigned kk, pp, bb, tt, one, q;
    kk  = keep_q;
    pp  = p;
    bb  = base_q;
    tt  = t;
    one = KEEP_ONE;
    q = (kk * pp * bb + (one - kk) * pp * tt) / (one * bb);
    return (q > CHAN_MAX) ? CHAN_MAX : q[CHAN_W-1:0];
  endfunction

  function automatic out_word_t blend_pixel(input in_word_t w);
    out_word_t r;
    r.out_a = blend_chan(w.chan_a, w.texture_level);
    if (mode_q == MODE_COLOR) begin
      r.out_b = blend_chan(w.chan_b, w.texture_level);
      r.out_c = blend_chan(w.chan_c, w.texture_level);
    end else begin
      r.out_b = w.chan_b;
      r.out_c = w.chan_c;
    end
    return r;
  endfunction

  task automatic push_pixel(input in_word_t w, input out_word_t want);
    int unsigned gap;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    blended_q.push_back(want);
    gap = smooth_flow ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (blended_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input logic [KEEP_W-1:0] keep_raw,
                                input logic [CHAN_W-1:0] base_raw,
                                input logic              mode_raw);
    cfg_we    <= 1'b1;
    cfg_index <= REG_KEEP;
    cfg_data  <= keep_raw;
    @(posedge clk);
    cfg_index <= REG_BASE;
    cfg_data  <= CFG_DATA_W'(base_raw);
    @(posedge clk);
    cfg_index <= REG_MODE;
    cfg_data  <= CFG_DATA_W'(mode_raw);
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    keep_q = (keep_raw > KEEP_ONE) ? KEEP_ONE : keep_raw;
    base_q = (base_raw == '0) ? BASE_MIN : base_raw;
    mode_q = mode_raw;
  endtask

  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      stall_left  <= LONG_HOLD;
      out_ready   <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (smooth_flow || $urandom_range(0, 9) < 7) begin
      out_ready <= 1'b1;
    end else begin
      stall_left <= idle_len();
      out_ready  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (blended_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, out_data);
        fail_count++;
      end else begin
        want = blended_q.pop_front();
        if (out_data.out_a !== want.out_a) begin
          $display("%0t: out_a expected %0d got %0d", $time, want.out_a, out_data.out_a);
          fail_count++;
        end
        if (out_data.out_b !== want.out_b) begin
          $display("%0t: out_b expected %0d got %0d", $time, want.out_b, out_data.out_b);
          fail_count++;
        end
        if (out_data.out_c !== want.out_c) begin
          $display("%0t: out_c expected %0d got %0d", $time, want.out_c, out_data.out_c);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[texture_modulate_pixel] ERROR");
      $finish;
    end
  end

  initial begin
    in_word_t          w;
    logic [KEEP_W-1:0] keep_raw;
    logic [CHAN_W-1:0] base_raw;
    int                t_near;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].set_cfg) begin
        settle();
        write_settings(DIRECTED[i].keep_raw, DIRECTED[i].base_raw, DIRECTED[i].mode_raw);
      end
      push_pixel(DIRECTED[i].pix,
                 DIRECTED[i].typed ? DIRECTED[i].want : blend_pixel(DIRECTED[i].pix));
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      smooth_flow = (ph == 5);
      case ($urandom_range(0, 4))
        0:       keep_raw = '0;
        1:       keep_raw = KEEP_ONE;
        2:       keep_raw = KEEP_W'($urandom);
        default: keep_raw = KEEP_W'($urandom_range(0, 65536));
      endcase
      case ($urandom_range(0, 3))
        0:       base_raw = '0;
        1:       base_raw = 8'd255;
        2:       base_raw = 8'd1;
        default: base_raw = CHAN_W'($urandom);
      endcase
      write_settings(keep_raw, base_raw, ph[0] ? MODE_COLOR : MODE_GRAY);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == 10) hold_requests++;
        if (ph == 4 && n == 25) settle();
        w = in_word_t'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          t_near = int'(base_q) + $urandom_range(0, 2) - 1;
          w.texture_level = CHAN_W'((t_near < 0) ? 0 : (t_near > 255) ? 255 : t_near);
        end
        push_pixel(w, blend_pixel(w));
      end
    end

    smooth_flow = 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("[texture_modulate_pixel] OK");
    end else begin
      $display("[texture_modulate_pixel] ERROR");
    end
    $finish;
  end

endmodule
